FILE: rtl/core/decc_pkg.sv
// Shared types, constants and helpers for the directed Euler circuit checker.
// No dependencies; used by every module of the block.
`default_nettype none
package decc_pkg;
	localparam int MAX_VERTICES = 64;
	localparam int VW           = $clog2(MAX_VERTICES);
	localparam int NW           = $clog2(MAX_VERTICES + 1);
	localparam int CNT_W        = 7;
	localparam int MAX_EDGES    = 4096;
	localparam int DEG_W        = $clog2(MAX_EDGES + 1);

	typedef logic [MAX_VERTICES-1:0] vmask_t;
	typedef logic [VW-1:0]           vidx_t;

	typedef enum logic [1:0] {
		CAUSE_OK   = 2'd0,
		CAUSE_CONN = 2'd1,
		CAUSE_DEG  = 2'd2,
		CAUSE_ERR  = 2'd3
	} cause_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // item beat accepted this cycle
		logic edge_wr;  // commit the latched edge
		logic init;     // seed search from start vertex
		logic pick;     // take next unprocessed visited vertex
		logic merge;    // fold its row into the visited set
		logic transp;   // search over the transpose
		logic sw_start; // degree sweep from vertex zero
		logic sw_next;  // advance degree sweep
		logic clear;    // drop graph state
	} decc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic item_last;
		logic err;
		logic any_out;
		logic any_in;
		logic cand_any;
		logic cover_ok;
		logic deg_eq;
		logic sw_last;
	} decc_sts_t;

	function automatic vidx_t low_index(input vmask_t m);
		vmask_t lb;
		vidx_t  idx;
		lb  = m & (~m + vmask_t'(1));
		idx = '0;
		for (int i = 0; i < MAX_VERTICES; i++)
			if (lb[i]) idx = idx | vidx_t'(i);
		return idx;
	endfunction

	function automatic vmask_t onehot(input vidx_t i);
		return vmask_t'(1) << i;
	endfunction
endpackage
`default_nettype wire

FILE: rtl/core/decc_ctrl.sv
// Sequencer of the Euler circuit checker: loading, two searches, degree sweep.
// Depends on decc_pkg; drives decc_dpath through command/status structs.
`default_nettype none
module decc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output logic                    done,
	output logic                    is_eulerian,
	output logic [1:0]              cause,
	output decc_pkg::decc_cmd_t     cmd,
	input  decc_pkg::decc_sts_t     sts
);
	import decc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_EDGE, S_EVAL, S_PICK, S_MERGE, S_SW_RD, S_SW_CHK, S_DONE
	} state_t;

	state_t state_q;
	logic   pass_q;
	logic   done_q;
	cause_t cause_q;

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign cause       = cause_q;
	assign is_eulerian = (cause_q == CAUSE_OK);

	always_comb begin
		cmd          = '0;
		cmd.transp   = pass_q;
		case (state_q)
			S_IDLE:   cmd.load = start;
			S_EDGE:   cmd.edge_wr = 1'b1;
			S_EVAL:   cmd.init = !sts.err && sts.any_out;
			S_PICK: begin
				cmd.pick     = sts.cand_any;
				cmd.init     = !sts.cand_any && sts.cover_ok && !pass_q;
				cmd.sw_start = !sts.cand_any && sts.cover_ok && pass_q;
			end
			S_MERGE:  cmd.merge = 1'b1;
			S_SW_CHK: cmd.sw_next = sts.deg_eq && !sts.sw_last;
			S_DONE:   cmd.clear = 1'b1;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q  <= 1'b0;
			done_q  <= 1'b0;
			cause_q <= CAUSE_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: if (start) state_q <= S_EDGE;
				S_EDGE: state_q <= sts.item_last ? S_EVAL : S_IDLE;
				S_EVAL: begin
					pass_q <= 1'b0;
					if (sts.err) begin
						cause_q <= CAUSE_ERR;
						done_q  <= 1'b1;
						state_q <= S_DONE;
					end else if (!sts.any_out) begin
						cause_q <= sts.any_in ? CAUSE_CONN : CAUSE_OK;
						done_q  <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					if (sts.cand_any) begin
						state_q <= S_MERGE;
					end else if (!sts.cover_ok) begin
						cause_q <= CAUSE_CONN;
						done_q  <= 1'b1;
						state_q <= S_DONE;
					end else if (!pass_q) begin
						pass_q <= 1'b1;
					end else begin
						state_q <= S_SW_RD;
					end
				end
				S_MERGE: state_q <= S_PICK;
				S_SW_RD: state_q <= S_SW_CHK;
				S_SW_CHK: begin
					if (!sts.deg_eq) begin
						cause_q <= CAUSE_DEG;
						done_q  <= 1'b1;
						state_q <= S_DONE;
					end else if (sts.sw_last) begin
						cause_q <= CAUSE_OK;
						done_q  <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SW_RD;
					end
				end
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/decc_dpath.sv
// Datapath: adjacency and transpose row memories, degree memories, masks.
// Depends on decc_pkg; steered by decc_ctrl.
`default_nettype none
module decc_dpath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	input  wire logic [decc_pkg::CNT_W-1:0]   cfg_data,
	input  wire logic [decc_pkg::VW-1:0]      src_vertex,
	input  wire logic [decc_pkg::VW-1:0]      dst_vertex,
	input  wire logic                         carries_edge,
	input  wire logic                         last_edge,
	input  decc_pkg::decc_cmd_t               cmd,
	output decc_pkg::decc_sts_t               sts
);
	import decc_pkg::*;

	logic [CNT_W-1:0] vcount_q;
	logic [NW-1:0]    n_eff;
	vmask_t           act_mask;

	vidx_t src_q, dst_q, u_q, v_q;
	logic  carries_q, last_q, ok_q, err_q;
	logic [DEG_W-1:0] total_q;
	vmask_t out_nz_q, in_nz_q, vis_q, proc_q;

	vmask_t adj_mem  [MAX_VERTICES];
	vmask_t adjt_mem [MAX_VERTICES];
	logic [DEG_W-1:0] odeg_mem [MAX_VERTICES];
	logic [DEG_W-1:0] ideg_mem [MAX_VERTICES];
	vmask_t adj_rd_q, adjt_rd_q;
	logic [DEG_W-1:0] odeg_rd_q, ideg_rd_q;

	vmask_t cand, row;
	vidx_t  cand_idx, start_idx;
	vidx_t  adj_addr, adjt_addr, odeg_addr, ideg_addr;
	logic   item_ok;
	logic [DEG_W-1:0] odeg_v, ideg_v;

	// 0 acts as 1, anything above capacity as capacity
	always_comb begin
		if (vcount_q == '0)
			n_eff = NW'(1);
		else if (int'(vcount_q) > MAX_VERTICES)
			n_eff = NW'(MAX_VERTICES);
		else
			n_eff = NW'(vcount_q);
		for (int i = 0; i < MAX_VERTICES; i++)
			act_mask[i] = (i < int'(n_eff));
	end

	assign item_ok = (int'(src_vertex) < int'(n_eff)) && (int'(dst_vertex) < int'(n_eff))
		&& (int'(total_q) < MAX_EDGES);

	assign cand      = vis_q & ~proc_q & act_mask;
	assign cand_idx  = low_index(cand);
	assign start_idx = low_index(out_nz_q & act_mask);
	assign row       = cmd.transp ? (in_nz_q[u_q] ? adjt_rd_q : '0)
	                              : (out_nz_q[u_q] ? adj_rd_q : '0);
	assign odeg_v    = out_nz_q[v_q] ? odeg_rd_q : '0;
	assign ideg_v    = in_nz_q[v_q] ? ideg_rd_q : '0;

	assign adj_addr  = cmd.load ? src_vertex : cand_idx;
	assign adjt_addr = cmd.load ? dst_vertex : cand_idx;
	assign odeg_addr = cmd.load ? src_vertex : v_q;
	assign ideg_addr = cmd.load ? dst_vertex : v_q;

	always_comb begin
		sts.item_last = last_q;
		sts.err       = err_q;
		sts.any_out   = |(out_nz_q & act_mask);
		sts.any_in    = |(in_nz_q & act_mask);
		sts.cand_any  = |cand;
		sts.cover_ok  = ((out_nz_q | in_nz_q) & act_mask & ~vis_q) == '0;
		sts.deg_eq    = (odeg_v == ideg_v);
		sts.sw_last   = (int'(v_q) == int'(n_eff) - 1);
	end

	// memories: registered reads, row/counter write-back of the latched edge
	always_ff @(posedge clk) begin
		adj_rd_q  <= adj_mem[adj_addr];
		adjt_rd_q <= adjt_mem[adjt_addr];
		odeg_rd_q <= odeg_mem[odeg_addr];
		ideg_rd_q <= ideg_mem[ideg_addr];
		if (cmd.edge_wr && carries_q && ok_q) begin
			adj_mem[src_q]  <= (out_nz_q[src_q] ? adj_rd_q : '0) | onehot(dst_q);
			adjt_mem[dst_q] <= (in_nz_q[dst_q] ? adjt_rd_q : '0) | onehot(src_q);
			odeg_mem[src_q] <= (out_nz_q[src_q] ? odeg_rd_q : '0) + DEG_W'(1);
			ideg_mem[dst_q] <= (in_nz_q[dst_q] ? ideg_rd_q : '0) + DEG_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q     <= src_vertex;
			dst_q     <= dst_vertex;
			carries_q <= carries_edge;
			last_q    <= last_edge;
			ok_q      <= item_ok;
		end
		if (cmd.pick)
			u_q <= cand_idx;
		if (cmd.sw_start)
			v_q <= '0;
		else if (cmd.sw_next)
			v_q <= v_q + VW'(1);
		if (cmd.init)
			vis_q <= onehot(start_idx);
		else if (cmd.merge)
			vis_q <= vis_q | (row & act_mask);
		if (cmd.init)
			proc_q <= '0;
		else if (cmd.pick)
			proc_q <= proc_q | onehot(cand_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= CNT_W'(MAX_VERTICES);
			out_nz_q <= '0;
			in_nz_q  <= '0;
			total_q  <= '0;
			err_q    <= 1'b0;
		end else begin
			if (cfg_valid)
				vcount_q <= cfg_data;
			if (cmd.clear) begin
				out_nz_q <= '0;
				in_nz_q  <= '0;
				total_q  <= '0;
				err_q    <= 1'b0;
			end else if (cmd.edge_wr && carries_q) begin
				if (ok_q) begin
					out_nz_q[src_q] <= 1'b1;
					in_nz_q[dst_q]  <= 1'b1;
					total_q         <= total_q + DEG_W'(1);
				end else begin
					err_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/directed_euler_circuit_check_unit.sv
// Top level of the directed Euler circuit checker.
// Depends on decc_pkg, decc_ctrl and decc_dpath.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  item in  | start & !busy           | src_vertex, dst_vertex, carries_edge, last_edge
//  verdict  | done (one-cycle strobe) | is_eulerian, cause
//  config   | cfg_valid & cfg_ready   | cfg_data (vertex_count)
//
// Each item beat has a memory read, then a row/degree write-back.
// After a last beat: a setup step, the two searches (a pick and a merge per
// reached vertex, shared row-read port), the degree sweep (a read and a check
// per vertex), and a final step that shows the verdict and drops the graph.
// Reset clears control and the per-vertex valid masks; cfg_ready is always high.
// The verdict cannot be stalled: done lasts exactly one cycle.
`default_nettype none
module directed_euler_circuit_check_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [decc_pkg::CNT_W-1:0] cfg_data,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [decc_pkg::VW-1:0]    src_vertex,
	input  wire logic [decc_pkg::VW-1:0]    dst_vertex,
	input  wire logic                       carries_edge,
	input  wire logic                       last_edge,
	output logic                            done,
	output logic                            is_eulerian,
	output logic [1:0]                      cause
);
	import decc_pkg::*;

	decc_cmd_t cmd;
	decc_sts_t sts;

	// register writes must be issued only while idle; the block does not enforce this and always takes them
	assign cfg_ready = 1'b1;

	decc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.done        (done),
		.is_eulerian (is_eulerian),
		.cause       (cause),
		.cmd         (cmd),
		.sts         (sts)
	);

	decc_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.src_vertex   (src_vertex),
		.dst_vertex   (dst_vertex),
		.carries_edge (carries_edge),
		.last_edge    (last_edge),
		.cmd          (cmd),
		.sts          (sts)
	);
endmodule
`default_nettype wire

FILE: rtl/core/decc_chk.sv
// Port-level checker for directed_euler_circuit_check_unit, bound to the top.
// Depends on decc_pkg.
`default_nettype none
module decc_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       last_edge,
	input wire logic       done,
	input wire logic       is_eulerian,
	input wire logic [1:0] cause
);
	import decc_pkg::*;

	a_strobe_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("verdict strobe longer than one cycle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("verdict outside a busy interval");

	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_eulerian == (cause == CAUSE_OK))) else $error("verdict and cause disagree");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted beat did not raise busy");

	a_no_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last_edge) |=> ##1 !done) else $error("verdict without last beat");
endmodule

bind directed_euler_circuit_check_unit decc_chk u_decc_chk (.*);
`default_nettype wire
